@@ rtl/spq_pkg.sv @@
`timescale 1ns / 1ps
// Package for the sorted priority queue: key width, operation and error codes,
// and the link and command structs passed along the cell chain. No dependencies.
package spq_pkg;

  localparam int KEY_W     = 8;
  localparam int DEPTH_DEF = 16;
  localparam int COUNT_W   = 5;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_EMPTY = 2'd1;
  localparam logic [1:0] ERR_FULL  = 2'd2;

  typedef struct packed {
    logic             ins_en;
    logic             rem_en;
    logic [KEY_W-1:0] key;
  } spq_cmd_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic             valid;
    logic             place;
  } spq_link_t;

endpackage

@@ rtl/spq_cell.sv @@
`timescale 1ns / 1ps
// One slot of the sorted chain: holds a key and its valid bit, and takes the
// new key, its left neighbor's entry or its right neighbor's entry. Uses spq_pkg.
module spq_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  spq_pkg::spq_cmd_t  cmd,
  input  spq_pkg::spq_link_t left_in,
  input  spq_pkg::spq_link_t right_in,
  output spq_pkg::spq_link_t link_out
);

  logic [spq_pkg::KEY_W-1:0] key_r;
  logic [spq_pkg::KEY_W-1:0] key_nxt;
  logic                      valid_r;
  logic                      valid_nxt;
  logic                      place;

  // The new key belongs here or further left when this slot is empty or smaller.
  assign place = !valid_r || (key_r < cmd.key);

  always_comb begin
    key_nxt   = key_r;
    valid_nxt = valid_r;
    if (cmd.ins_en && place) begin
      if (left_in.place) begin
        key_nxt   = left_in.key;
        valid_nxt = left_in.valid;
      end else begin
        key_nxt   = cmd.key;
        valid_nxt = 1'b1;
      end
    end else if (cmd.rem_en) begin
      key_nxt   = right_in.key;
      valid_nxt = right_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign link_out = '{key: key_r, valid: valid_r, place: place};

endmodule

@@ rtl/sorted_priority_queue_unit.sv @@
`timescale 1ns / 1ps
// Top level of the sorted priority queue: a chain of spq_cell slots, the fill
// counter and the result register. Uses spq_pkg and spq_cell.
//
//  Channel  Ports                                           Handshake
//  input    in_kind, in_age                                 start high, busy low
//  result   out_removed_age, out_removed_valid,             out_strobe, one cycle
//           out_error, out_count
//
// Every operation is handled by the cell chain as a whole; all slots compare and
// shift in parallel, so a new beat is accepted in every cycle and busy stays low.
// Its result appears on the result ports in the cycle after acceptance.
// Synchronous reset empties the queue; no clearing pass is needed.
// The receiver cannot stall, so results are never held.
module sorted_priority_queue_unit #(
  parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic                      in_kind,
  input  logic [spq_pkg::KEY_W-1:0] in_age,
  output logic                      out_strobe,
  output logic [spq_pkg::KEY_W-1:0] out_removed_age,
  output logic                      out_removed_valid,
  output logic [1:0]                out_error,
  output logic [spq_pkg::COUNT_W-1:0] out_count
);

  localparam int CW = $clog2(DEPTH + 1);

  spq_pkg::spq_cmd_t  cmd;
  spq_pkg::spq_link_t links [DEPTH];
  spq_pkg::spq_link_t lefts [DEPTH];
  spq_pkg::spq_link_t rights[DEPTH];
  logic [DEPTH-1:0]   valid_vec;

  logic [CW-1:0] cnt_r;
  logic [CW-1:0] cnt_nxt;
  logic          accept;
  logic          full;
  logic          empty;
  logic [1:0]    err;

  logic                      out_strobe_r;
  logic [spq_pkg::KEY_W-1:0] out_removed_age_r;
  logic                      out_removed_valid_r;
  logic [1:0]                out_error_r;
  logic [CW+spq_pkg::COUNT_W-1:0] cnt_ext;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (cnt_r == CW'(DEPTH));
  assign empty  = (cnt_r == '0);

  assign cmd.ins_en = accept && (in_kind == spq_pkg::KIND_INSERT) && !full;
  assign cmd.rem_en = accept && (in_kind == spq_pkg::KIND_REMOVE) && !empty;
  assign cmd.key    = in_age;

  always_comb begin
    err = spq_pkg::ERR_NONE;
    if (in_kind == spq_pkg::KIND_INSERT && full) begin
      err = spq_pkg::ERR_FULL;
    end else if (in_kind == spq_pkg::KIND_REMOVE && empty) begin
      err = spq_pkg::ERR_EMPTY;
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.ins_en) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (cmd.rem_en) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      if (gi == 0) begin : g_first
        assign lefts[gi] = '{key: '0, valid: 1'b0, place: 1'b0};
      end else begin : g_mid_l
        assign lefts[gi] = links[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_last
        assign rights[gi] = '{key: '0, valid: 1'b0, place: 1'b0};
      end else begin : g_mid_r
        assign rights[gi] = links[gi+1];
      end
      assign valid_vec[gi] = links[gi].valid;

      spq_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .left_in  (lefts[gi]),
        .right_in (rights[gi]),
        .link_out (links[gi])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      cnt_r        <= cnt_nxt;
      out_strobe_r <= accept;
    end
    if (accept) begin
      out_removed_age_r   <= cmd.rem_en ? links[0].key : '0;
      out_removed_valid_r <= cmd.rem_en;
      out_error_r         <= err;
    end
  end

  assign cnt_ext           = {{spq_pkg::COUNT_W{1'b0}}, cnt_r};
  assign out_strobe        = out_strobe_r;
  assign out_removed_age   = out_removed_age_r;
  assign out_removed_valid = out_removed_valid_r;
  assign out_error         = out_error_r;
  assign out_count         = cnt_ext[spq_pkg::COUNT_W-1:0];

  a_strobe_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_strobe)
    else $error("result strobe missing after an accepted beat");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("fill count exceeds depth");

  a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    ((valid_vec + DEPTH'(1)) & valid_vec) == '0)
    else $error("occupied slots are not a contiguous prefix");

  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_vec) == int'(cnt_r))
    else $error("fill count disagrees with occupied slots");

  a_removed_no_error: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_removed_valid) |-> out_error == spq_pkg::ERR_NONE)
    else $error("removed key reported together with an error");

endmodule
